// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define RBC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under reset.
`define RBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rbc_pkg.sv =====
package rbc_pkg;

   localparam int MAX_POLES_DEFAULT = 16;
   localparam int HW = 40;            // homogeneous lane width, Q24.16
   localparam int NUM_W = 56;         // dividend width
   localparam int DEN_W = 24;         // divisor width, weight Q8.16
   localparam logic [4:0] POLE_COUNT_RESET = 5'd4;
   localparam logic [16:0] T_ONE = 17'd65536;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef struct packed {
      logic              command;
      logic [3:0]        pole_index;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic [23:0]       weight;
      logic [16:0]       param_t;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic              zero_weight;
   } rsp_type;

   typedef struct packed {
      logic signed [HW-1:0] hx;
      logic signed [HW-1:0] hy;
      logic signed [HW-1:0] hz;
      logic signed [HW-1:0] hw;
   } hpoint_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ===== rtl/rbc_cell.sv =====
module rbc_cell (
   input  logic                clock,
   input  rbc_pkg::cell_ctl_type ctl,
   input  rbc_pkg::hpoint_type from_right,
   input  rbc_pkg::hpoint_type ins,
   output rbc_pkg::hpoint_type q
);

   rbc_pkg::hpoint_type cell_ff;

   // advance toward the head; the tail cell of the active run takes the new point
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         cell_ff <= ctl.load ? ins : from_right;
      end
   end

   assign q = cell_ff;

endmodule

// ===== rtl/rbc_div.sv =====
module rbc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rbc_pkg::NUM_W-1:0] num,
   input  logic [rbc_pkg::DEN_W-1:0] den,
   output logic [rbc_pkg::NUM_W-1:0] quot,
   output logic                      done
);

   localparam int CNT_W = $clog2(rbc_pkg::NUM_W + 1);

   logic [rbc_pkg::NUM_W-1:0] num_ff;
   logic [rbc_pkg::NUM_W-1:0] quo_ff;
   logic [rbc_pkg::DEN_W-1:0] den_ff;
   logic [rbc_pkg::DEN_W:0]   rem_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [rbc_pkg::DEN_W:0]   rem_sh;
   logic                      fits;

   always_comb begin
      rem_sh = {rem_ff[rbc_pkg::DEN_W-1:0], num_ff[rbc_pkg::NUM_W-1]};
      fits   = rem_sh >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(rbc_pkg::NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // one quotient bit per cycle, restoring
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[rbc_pkg::NUM_W-2:0], 1'b0};
         rem_ff <= fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_ff <= {quo_ff[rbc_pkg::NUM_W-2:0], fits};
      end
   end

   assign quot = quo_ff;
   assign done = done_ff;

endmodule

// ===== rtl/rational_bezier_curve_point_core.sv =====
// Rational Bezier curve point, de Casteljau evaluation in fixed point.
// Channels: req_* carries a request (load one control point, or evaluate
// at param_t); rsp_* returns one point per evaluate request, none per load.
// csr_* writes pole_count (always ready; write it only while idle).
// A load request only writes the pole store. An evaluate request runs:
//   lift     pole store read, weight multiply, push into chain
//   reduce   n-1 levels; a level of length L makes L-1 interpolations,
//            each a STEP_A/STEP_B pair on the shared blend multiplier,
//            then one DROP of the spent head
//   divide   DIV0 starts the bit-serial x/y/z dividers in parallel for 56
//            quotient bits; skipped when the final weight is zero or negative
//   output   load into the result register
// One evaluate at a time; the next request is taken the cycle after
// the result loads.
// Points live in a row of cells that shift toward the head; the blend unit
// reads the two head cells and writes into the tail of the active run.
// Reset clears the control state and sets pole_count to 4; the pole store
// is not cleared and a pole must be loaded before it is used.
// When the receiver stalls the result is held in rsp_payload; new requests
// are still accepted, and an evaluate that finishes waits for the register.
module rational_bezier_curve_point_core #(
   parameter int MAX_POLES = rbc_pkg::MAX_POLES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbc_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [4:0]       csr_data
);

   localparam int AW = $clog2(MAX_POLES);
   localparam int CW = $clog2(MAX_POLES + 1);
   localparam int HW = rbc_pkg::HW;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LIFT   = 3'd1;
   localparam logic [2:0] ST_STEP_A = 3'd2;
   localparam logic [2:0] ST_STEP_B = 3'd3;
   localparam logic [2:0] ST_DROP   = 3'd4;
   localparam logic [2:0] ST_DIV0   = 3'd5;
   localparam logic [2:0] ST_DIV    = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  pole_count_ff;
   logic [CW-1:0] n_ff, n_in, n_eff;
   logic [16:0] t_ff;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] ins_cnt_ff, ins_cnt_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] step_ff, step_in;
   logic        rd_v_ff, mul_v_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rbc_pkg::rsp_type rsp_ff, rsp_in;
   logic        zw_ff, zw_in;
   logic [2:0]  neg_ff;

   logic req_fire, load_fire, eval_fire, rd_issue, out_load, div_start;

   // pole store
   logic [31:0] mem_x [MAX_POLES];
   logic [31:0] mem_y [MAX_POLES];
   logic [31:0] mem_z [MAX_POLES];
   logic [23:0] mem_w [MAX_POLES];
   logic [31:0] rd_x_ff, rd_y_ff, rd_z_ff;
   logic [23:0] rd_w_ff, mul_w_ff;
   logic signed [56:0] px_ff, py_ff, pz_ff;
   logic signed [56:0] rx, ry, rz;

   // chain and blend unit
   rbc_pkg::hpoint_type cells [MAX_POLES];
   rbc_pkg::cell_ctl_type cell_ctl [MAX_POLES];
   rbc_pkg::hpoint_type ins_pt, lift_pt, blend_pt, a_ff;
   logic signed [58:0] bx_ff, by_ff, bz_ff, bw_ff;
   logic signed [17:0] t_s;
   logic [AW-1:0] tail;
   logic chain_shift, chain_load;

   // divider
   logic [HW-1:0] mag_x, mag_y, mag_z;
   logic [rbc_pkg::NUM_W-1:0] num_x, num_y, num_z, q_x, q_y, q_z;
   logic [rbc_pkg::DEN_W-1:0] den;
   logic div_done, div_done_y, div_done_z;
   logic w_bad;

   function automatic logic [31:0] sat_q(input logic neg,
                                         input logic [rbc_pkg::NUM_W-1:0] q);
      logic [32:0] m;
      begin
         m = 33'd0;
         if (!neg) begin
            sat_q = (q > rbc_pkg::NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
         end else begin
            m = (q > rbc_pkg::NUM_W'(33'h1_0000_0000 >> 1)) ? 33'h0_8000_0000 : q[32:0];
            sat_q = 32'(33'd0 - m);
         end
      end
   endfunction

   function automatic logic signed [58:0] bl_prod(input logic signed [HW-1:0] a,
                                                  input logic signed [HW-1:0] b,
                                                  input logic signed [17:0] t);
      logic signed [HW:0] d;
      begin
         d = $signed({b[HW-1], b}) - $signed({a[HW-1], a});
         bl_prod = 59'(d * t);
      end
   endfunction

   function automatic logic signed [HW-1:0] bl_sum(input logic signed [HW-1:0] a,
                                                   input logic signed [58:0] p);
      logic signed [58:0] r;
      begin
         r = p + 59'sd32768;
         bl_sum = a + r[HW+15:16];
      end
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && (req_payload.command == rbc_pkg::CMD_LOAD);
   assign eval_fire = req_fire && (req_payload.command == rbc_pkg::CMD_EVAL);

   always_comb begin
      if (pole_count_ff == 5'd0) begin
         n_eff = CW'(1);
      end else if (int'(pole_count_ff) > MAX_POLES) begin
         n_eff = CW'(MAX_POLES);
      end else begin
         n_eff = CW'(pole_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_count_ff <= rbc_pkg::POLE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         pole_count_ff <= csr_data;
      end
   end

   // store writes and registered reads
   always_ff @(posedge clock) begin
      if (load_fire && (int'(req_payload.pole_index) < MAX_POLES)) begin
         mem_x[AW'(req_payload.pole_index)] <= req_payload.coord_x;
         mem_y[AW'(req_payload.pole_index)] <= req_payload.coord_y;
         mem_z[AW'(req_payload.pole_index)] <= req_payload.coord_z;
         mem_w[AW'(req_payload.pole_index)] <= req_payload.weight;
      end
      rd_x_ff <= mem_x[rd_idx_ff[AW-1:0]];
      rd_y_ff <= mem_y[rd_idx_ff[AW-1:0]];
      rd_z_ff <= mem_z[rd_idx_ff[AW-1:0]];
      rd_w_ff <= mem_w[rd_idx_ff[AW-1:0]];
   end

   // lift to homogeneous form
   always_ff @(posedge clock) begin
      px_ff    <= 57'($signed(rd_x_ff) * $signed({1'b0, rd_w_ff}));
      py_ff    <= 57'($signed(rd_y_ff) * $signed({1'b0, rd_w_ff}));
      pz_ff    <= 57'($signed(rd_z_ff) * $signed({1'b0, rd_w_ff}));
      mul_w_ff <= rd_w_ff;
   end

   always_comb begin
      rx = px_ff + 57'sd32768;
      ry = py_ff + 57'sd32768;
      rz = pz_ff + 57'sd32768;
      lift_pt.hx = rx[55:16];
      lift_pt.hy = ry[55:16];
      lift_pt.hz = rz[55:16];
      lift_pt.hw = $signed({16'd0, mul_w_ff});
   end

   // blend: a + round((b - a) * t), two head cells
   assign t_s = $signed({1'b0, t_ff});

   always_ff @(posedge clock) begin
      if (state_ff == ST_STEP_A) begin
         bx_ff <= bl_prod(cells[0].hx, cells[1].hx, t_s);
         by_ff <= bl_prod(cells[0].hy, cells[1].hy, t_s);
         bz_ff <= bl_prod(cells[0].hz, cells[1].hz, t_s);
         bw_ff <= bl_prod(cells[0].hw, cells[1].hw, t_s);
         a_ff  <= cells[0];
      end
   end

   always_comb begin
      blend_pt.hx = bl_sum(a_ff.hx, bx_ff);
      blend_pt.hy = bl_sum(a_ff.hy, by_ff);
      blend_pt.hz = bl_sum(a_ff.hz, bz_ff);
      blend_pt.hw = bl_sum(a_ff.hw, bw_ff);
   end

   always_comb begin
      ins_pt      = (state_ff == ST_LIFT) ? lift_pt : blend_pt;
      chain_load  = ((state_ff == ST_LIFT) && mul_v_ff) || (state_ff == ST_STEP_B);
      chain_shift = chain_load || (state_ff == ST_DROP);
      if (state_ff == ST_LIFT) begin
         tail = AW'(n_ff - 1'b1);
      end else begin
         tail = AW'(len_ff - 1'b1);
      end
   end

   genvar j;
   generate
      for (j = 0; j < MAX_POLES; j++) begin : g_chain
         assign cell_ctl[j].shift = chain_shift;
         assign cell_ctl[j].load  = chain_load && (tail == AW'(j));
         if (j == MAX_POLES - 1) begin : g_last
            rbc_cell u_cell (
               .clock      (clock),
               .ctl        (cell_ctl[j]),
               .from_right (ins_pt),
               .ins        (ins_pt),
               .q          (cells[j])
            );
         end else begin : g_mid
            rbc_cell u_cell (
               .clock      (clock),
               .ctl        (cell_ctl[j]),
               .from_right (cells[j+1]),
               .ins        (ins_pt),
               .q          (cells[j])
            );
         end
      end
   endgenerate

   // projection by the final weight
   always_comb begin
      w_bad = cells[0].hw[HW-1] || (cells[0].hw == '0);
      den   = cells[0].hw[rbc_pkg::DEN_W-1:0];
      mag_x = cells[0].hx[HW-1] ? HW'(-cells[0].hx) : cells[0].hx;
      mag_y = cells[0].hy[HW-1] ? HW'(-cells[0].hy) : cells[0].hy;
      mag_z = cells[0].hz[HW-1] ? HW'(-cells[0].hz) : cells[0].hz;
      num_x = {mag_x, 16'd0} + rbc_pkg::NUM_W'(den >> 1);
      num_y = {mag_y, 16'd0} + rbc_pkg::NUM_W'(den >> 1);
      num_z = {mag_z, 16'd0} + rbc_pkg::NUM_W'(den >> 1);
   end

   assign div_start = (state_ff == ST_DIV0) && !w_bad;

   rbc_div u_div_x (.clock(clock), .reset(reset), .start(div_start),
                    .num(num_x), .den(den), .quot(q_x), .done(div_done));
   rbc_div u_div_y (.clock(clock), .reset(reset), .start(div_start),
                    .num(num_y), .den(den), .quot(q_y), .done(div_done_y));
   rbc_div u_div_z (.clock(clock), .reset(reset), .start(div_start),
                    .num(num_z), .den(den), .quot(q_z), .done(div_done_z));

   always_ff @(posedge clock) begin
      if (div_start) begin
         neg_ff <= {cells[0].hz[HW-1], cells[0].hy[HW-1], cells[0].hx[HW-1]};
      end
   end

   // sequencer
   assign rd_issue = (state_ff == ST_LIFT) && (rd_idx_ff < n_ff);
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      rd_idx_in  = rd_idx_ff;
      ins_cnt_in = ins_cnt_ff;
      len_in     = len_ff;
      step_in    = step_ff;
      zw_in      = zw_ff;
      case (state_ff)
         ST_IDLE: begin
            if (eval_fire) begin
               n_in       = n_eff;
               rd_idx_in  = '0;
               ins_cnt_in = '0;
               state_in   = ST_LIFT;
            end
         end
         ST_LIFT: begin
            if (rd_issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (mul_v_ff) begin
               ins_cnt_in = ins_cnt_ff + 1'b1;
               if (ins_cnt_ff == n_ff - 1'b1) begin
                  len_in   = n_ff;
                  step_in  = '0;
                  state_in = (n_ff == CW'(1)) ? ST_DIV0 : ST_STEP_A;
               end
            end
         end
         ST_STEP_A: begin
            state_in = ST_STEP_B;
         end
         ST_STEP_B: begin
            if (step_ff == len_ff - CW'(2)) begin
               state_in = ST_DROP;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_STEP_A;
            end
         end
         ST_DROP: begin
            len_in   = len_ff - 1'b1;
            step_in  = '0;
            state_in = (len_ff == CW'(2)) ? ST_DIV0 : ST_STEP_A;
         end
         ST_DIV0: begin
            zw_in    = w_bad;
            state_in = w_bad ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (zw_ff) begin
            rsp_in.point_x = '0;
            rsp_in.point_y = '0;
            rsp_in.point_z = '0;
         end else begin
            rsp_in.point_x = sat_q(neg_ff[0], q_x);
            rsp_in.point_y = sat_q(neg_ff[1], q_y);
            rsp_in.point_z = sat_q(neg_ff[2], q_z);
         end
         rsp_in.zero_weight = zw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
         mul_v_ff     <= 1'b0;
         n_ff         <= CW'(1);
         rd_idx_ff    <= '0;
         ins_cnt_ff   <= '0;
         len_ff       <= CW'(2);
         step_ff      <= '0;
         zw_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_v_ff      <= rd_issue;
         mul_v_ff     <= rd_v_ff;
         n_ff         <= n_in;
         rd_idx_ff    <= rd_idx_in;
         ins_cnt_ff   <= ins_cnt_in;
         len_ff       <= len_in;
         step_ff      <= step_in;
         zw_ff        <= zw_in;
      end
   end

   // hold the parameter and the result payload
   always_ff @(posedge clock) begin
      if (eval_fire) begin
         t_ff <= (req_payload.param_t > rbc_pkg::T_ONE) ? rbc_pkg::T_ONE
                                                        : req_payload.param_t;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`include "assert_macros.svh"

   `RBC_ASSERT_NEXT(a_eval_starts, clock, reset, eval_fire, state_ff == ST_LIFT, "evaluate request did not start the lift")
   `RBC_ASSERT_IMPL(a_zero_point, clock, reset, rsp_valid && rsp_payload.zero_weight, rsp_payload.point_x == 0 && rsp_payload.point_y == 0 && rsp_payload.point_z == 0, "zero weight result with nonzero point")
   `RBC_ASSERT_IMPL(a_len_range, clock, reset, state_ff == ST_STEP_A || state_ff == ST_STEP_B || state_ff == ST_DROP, len_ff >= CW'(2) && len_ff <= n_ff, "chain length out of range")
   `RBC_ASSERT_IMPL(a_div_in_sync, clock, reset, div_done, div_done_y && div_done_z && state_ff == ST_DIV, "dividers out of step")

endmodule

// ===== verif/tb_rational_bezier_curve_point_core.sv =====
`timescale 1ns / 100ps

module tb_rational_bezier_curve_point_core;

   localparam int NPOLE = 16;
   localparam int SETTLE_CYCLES = 400;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   rbc_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   rbc_pkg::rsp_type rsp_payload;
   logic             csr_valid;
   logic             csr_ready;
   logic [4:0]       csr_data;

   // Requests waiting to be driven, and points the curve should produce.
   rbc_pkg::req_type pending_reqs[$];
   rbc_pkg::rsp_type expected_points[$];

   // Shadow of the pole store and the pole count.
   logic signed [31:0] shadow_x [NPOLE];
   logic signed [31:0] shadow_y [NPOLE];
   logic signed [31:0] shadow_z [NPOLE];
   logic [23:0]        shadow_w [NPOLE];
   logic [4:0]         shadow_count;

   int   error_count;
   int   cycle_count;
   logic req_fire;

   rational_bezier_curve_point_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Round to nearest on a Q.16 product, ties toward plus infinity.
   function automatic longint round_q16(longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   // Divide homogeneous coordinate by weight, round half away from zero, saturate.
   function automatic logic [31:0] project_q16(longint h, longint w);
      longint unsigned mag;
      longint unsigned quo;
      mag = (h < 0) ? longint'(-h) : longint'(h);
      quo = ((mag << 16) + (longint'(w) >> 1)) / longint'(w);
      if (h >= 0) begin
         if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
         return quo[31:0];
      end
      if (quo > 64'h8000_0000) quo = 64'h8000_0000;
      return (~quo[31:0]) + 32'd1;
   endfunction

   // Rational de Casteljau on the shadow store.
   function automatic rbc_pkg::rsp_type curve_point(logic [16:0] t_in);
      longint  hx [NPOLE];
      longint  hy [NPOLE];
      longint  hz [NPOLE];
      longint  hw [NPOLE];
      longint  t;
      longint  w;
      int      n;
      rbc_pkg::rsp_type pt;
      t = (t_in > rbc_pkg::T_ONE) ? longint'(rbc_pkg::T_ONE) : longint'(t_in);
      n = (shadow_count == 0) ? 1 : (shadow_count > NPOLE) ? NPOLE : int'(shadow_count);
      for (int i = 0; i < n; i++) begin
         w = longint'({40'd0, shadow_w[i]});
         hx[i] = round_q16(longint'(shadow_x[i]) * w);
         hy[i] = round_q16(longint'(shadow_y[i]) * w);
         hz[i] = round_q16(longint'(shadow_z[i]) * w);
         hw[i] = w;
      end
      for (int r = 1; r < n; r++) begin
         for (int i = 0; i + r < n; i++) begin
            hx[i] = round_q16(hx[i] * (65536 - t) + hx[i+1] * t);
            hy[i] = round_q16(hy[i] * (65536 - t) + hy[i+1] * t);
            hz[i] = round_q16(hz[i] * (65536 - t) + hz[i+1] * t);
            hw[i] = round_q16(hw[i] * (65536 - t) + hw[i+1] * t);
         end
      end
      if (hw[0] <= 0) begin
         pt = '0;
         pt.zero_weight = 1'b1;
      end else begin
         pt.point_x = project_q16(hx[0], hw[0]);
         pt.point_y = project_q16(hy[0], hw[0]);
         pt.point_z = project_q16(hz[0], hw[0]);
         pt.zero_weight = 1'b0;
      end
      return pt;
   endfunction

   // Queue one pole load.
   task automatic push_load(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [23:0] w);
      rbc_pkg::req_type rq;
      rq = '0;
      rq.command = rbc_pkg::CMD_LOAD;
      rq.pole_index = idx[3:0];
      rq.coord_x = x;
      rq.coord_y = y;
      rq.coord_z = z;
      rq.weight = w;
      rq.param_t = 17'($urandom);  // ignored on a load
      pending_reqs.push_back(rq);
   endtask

   // Queue one evaluate; the coordinate fields are don't-care, fill them anyway.
   task automatic push_eval(logic [16:0] t);
      rbc_pkg::req_type rq;
      rq = '0;
      rq.command = rbc_pkg::CMD_EVAL;
      rq.pole_index = 4'($urandom);
      rq.coord_x = $urandom;
      rq.coord_y = $urandom;
      rq.coord_z = $urandom;
      rq.weight = 24'($urandom);
      rq.param_t = t;
      pending_reqs.push_back(rq);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(0, 32'h0A00_0000) - 32'h0500_0000;
      endcase
   endfunction

   function automatic logic [23:0] rand_weight();
      case ($urandom_range(0, 9))
         0:       return 24'd0;
         1:       return 24'h01_0000;
         2:       return 24'($urandom_range(1, 8));
         3, 4:    return 24'($urandom);
         default: return 24'($urandom_range(24'h00_4000, 24'h04_0000));
      endcase
   endfunction

   function automatic logic [16:0] rand_param();
      case ($urandom_range(0, 7))
         0:       return 17'd0;
         1:       return rbc_pkg::T_ONE;
         2:       return 17'($urandom);
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // Hold back a side about a third of the time, except in one long quiet window.
   function automatic logic idle_now();
      if (cycle_count > 30000 && cycle_count < 90000) return 1'b0;
      return $urandom_range(0, 99) < 33;
   endfunction

   // Record the accept, predict, and compare results.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_fire <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         if (req_payload.command == rbc_pkg::CMD_LOAD) begin
            shadow_x[req_payload.pole_index] = req_payload.coord_x;
            shadow_y[req_payload.pole_index] = req_payload.coord_y;
            shadow_z[req_payload.pole_index] = req_payload.coord_z;
            shadow_w[req_payload.pole_index] = req_payload.weight;
         end else begin
            expected_points.push_back(curve_point(req_payload.param_t));
         end
      end
      if (!reset && csr_valid && csr_ready)
         shadow_count = csr_data;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected point %h", $time, rsp_payload);
            error_count++;
         end else begin
            rbc_pkg::rsp_type want;
            want = expected_points.pop_front();
            if (rsp_payload.point_x !== want.point_x)
               $display("%0t: point_x expected %h actual %h", $time,
                        want.point_x, rsp_payload.point_x);
            if (rsp_payload.point_y !== want.point_y)
               $display("%0t: point_y expected %h actual %h", $time,
                        want.point_y, rsp_payload.point_y);
            if (rsp_payload.point_z !== want.point_z)
               $display("%0t: point_z expected %h actual %h", $time,
                        want.point_z, rsp_payload.point_z);
            if (rsp_payload.zero_weight !== want.zero_weight)
               $display("%0t: zero_weight expected %b actual %b", $time,
                        want.zero_weight, rsp_payload.zero_weight);
            if (rsp_payload !== want) error_count++;
         end
      end
   end

   // Drive requests and the result-side stall on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_now();
         // Hold the request until it is taken; then advance or idle.
         if (!req_valid || req_fire) begin
            if (pending_reqs.size() != 0 && !idle_now()) begin
               req_payload <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_points.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_pole_count(logic [4:0] value);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int counts[$];
      int nitems;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      error_count = 0;
      cycle_count = 0;
      req_fire = 1'b0;
      shadow_count = rbc_pkg::POLE_COUNT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: fill every pole, hit zero weight, saturation and t extremes.
      for (int i = 0; i < NPOLE; i++)
         push_load(i, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 24'd0);
      push_eval(17'd0);
      push_eval(rbc_pkg::T_ONE);
      push_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 24'd1);
      push_eval(17'd0);
      push_load(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
      push_eval(rbc_pkg::T_ONE);
      push_eval(17'h1FFFF);
      push_eval(17'd32768);
      wait_drained();

      // Pole count settings, after the directed part ran at the reset value; extremes early.
      counts = '{1, 0, 16, 31, 17, 2, 3, 4, 5, 2, 3, 6, 1, 4, 8, 3};
      foreach (counts[p]) begin
         write_pole_count(5'(counts[p]));
         nitems = (counts[p] >= 8) ? 40 : 135;
         for (int k = 0; k < nitems; k++) begin
            if ($urandom_range(0, 1))
               push_load($urandom_range(0, NPOLE - 1), rand_coord(), rand_coord(),
                         rand_coord(), rand_weight());
            else
               push_eval(rand_param());
         end
         wait_drained();
      end

      if (error_count == 0 && expected_points.size() == 0)
         $display("tb_rational_bezier_curve_point_core: clean");
      else
         $display("tb_rational_bezier_curve_point_core: errors");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_rational_bezier_curve_point_core: errors");
      $finish;
   end

endmodule
